// ----- design/chlcd_pkg.sv -----
// Package for the character LCD nibble sequencer: opcodes, control word
// layout and the microcode ROM. No dependencies.
`timescale 1ns / 1ps

package chlcd_pkg;

    localparam int unsigned STEP_W = 5;

    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_COMMAND = 2'd1,
        OP_DATA = 2'd2,
        OP_MOVE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_HIGH = 2'd1,
        SRC_LOW = 2'd2
    } nibble_src_t;

    typedef struct packed {
        nibble_src_t src;
        logic [3:0] nibble;
        logic [7:0] wait_ms;
        logic last;
        logic rs_pending;
    } ctrl_word_t;

    localparam logic [STEP_W-1:0] INIT_ENTRY = 5'd0;
    localparam logic [STEP_W-1:0] BYTE_ENTRY = 5'd16;
    localparam logic [STEP_W-1:0] LAST_ADDR = 5'd17;

    localparam logic [0:0] ADDR_STROBE_WAIT = 1'b0;
    localparam logic [7:0] STROBE_WAIT_RESET = 8'd2;

    function automatic ctrl_word_t rom_word(input logic [STEP_W-1:0] addr);
        ctrl_word_t w;
        w = '{src: SRC_CONST, nibble: 4'h0, wait_ms: 8'd0, last: 1'b0,
              rs_pending: 1'b0};
        case (addr)
            5'd0: begin w.nibble = 4'h3; w.wait_ms = 8'd120; end
            5'd1: begin w.nibble = 4'h3; w.wait_ms = 8'd80; end
            5'd2: begin w.nibble = 4'h3; w.wait_ms = 8'd50; end
            5'd3: begin w.nibble = 4'h2; w.wait_ms = 8'd50; end
            5'd4: begin w.nibble = 4'h2; w.wait_ms = 8'd50; end
            5'd5: w.nibble = 4'h8;
            5'd6: w.nibble = 4'h0;
            5'd7: w.nibble = 4'h8;
            5'd8: w.nibble = 4'h0;
            5'd9: w.nibble = 4'h6;
            5'd10: w.nibble = 4'h0;
            5'd11: w.nibble = 4'h1;
            5'd12: w.nibble = 4'h0;
            5'd13: w.nibble = 4'hF;
            5'd14: w.nibble = 4'h0;
            5'd15: begin w.nibble = 4'h1; w.last = 1'b1; end
            5'd16: begin w.src = SRC_HIGH; w.rs_pending = 1'b1; end
            5'd17: begin w.src = SRC_LOW; w.rs_pending = 1'b1; w.last = 1'b1; end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

endpackage

// ----- design/char_lcd_nibble_sequencer_core.sv -----
// Top level of the character LCD nibble sequencer: request decode, step
// counter over the microcode ROM, result register and APB register.
// Depends on chlcd_pkg.
`timescale 1ns / 1ps

// Takes one request per transaction and emits its LCD nibble transfers, high
// nibble first, one per cycle while the sink is ready: an init request runs
// the sixteen-step init program and gives 16 transactions, a command, data or
// valid cursor move request gives 2. A request is taken when the block is idle
// and is registered; the step counter then walks the ROM one word per transfer,
// and no new request is taken until its last transfer is loaded.
// A cursor move with a line above 1 or a column above 15 is dropped with no
// output. The strobe_wait_ms register (byte address 0) is stored and readable.
module char_lcd_nibble_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[1:0], byte_value[9:2], line[11:10], column[17:12], zero pad
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // reg_select[0], nibble[4:1], wait_before_ms[12:5], zero pad
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [chlcd_pkg::STEP_W-1:0] step_reg, step_next;
    logic busy_reg, busy_next;
    logic [7:0] pending_byte_reg, pending_byte_next;
    logic pending_select_reg, pending_select_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic m_tlast_reg, m_tlast_next;
    logic [12:0] m_data_reg, m_data_next;
    logic [7:0] strobe_wait_reg;

    chlcd_pkg::opcode_t opcode;
    logic [7:0] byte_value;
    logic [1:0] line;
    logic [5:0] column;
    chlcd_pkg::ctrl_word_t word;
    logic [3:0] nib;
    logic load_ok;

    assign opcode = chlcd_pkg::opcode_t'(s_tdata[1:0]);
    assign byte_value = s_tdata[9:2];
    assign line = s_tdata[11:10];
    assign column = s_tdata[17:12];

    assign s_tready = ~busy_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast = m_tlast_reg;
    assign m_tdata = {3'b000, m_data_reg};
    assign pready = 1'b1;
    assign prdata = (paddr[2] == chlcd_pkg::ADDR_STROBE_WAIT && paddr[1:0] == 2'b00)
                    ? {24'd0, strobe_wait_reg} : 32'd0;

    assign word = chlcd_pkg::rom_word(step_reg);
    assign load_ok = ~m_tvalid_reg | m_tready;

    always_comb
    begin
        case (word.src)
            chlcd_pkg::SRC_HIGH: nib = pending_byte_reg[7:4];
            chlcd_pkg::SRC_LOW: nib = pending_byte_reg[3:0];
            default: nib = word.nibble;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        pending_byte_next = pending_byte_reg;
        pending_select_next = pending_select_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tlast_next = m_tlast_reg;
        m_data_next = m_data_reg;

        if (busy_reg)
        begin
            if (load_ok)
            begin
                m_tvalid_next = 1'b1;
                m_tlast_next = word.last;
                m_data_next = {word.wait_ms, nib, word.rs_pending & pending_select_reg};
                step_next = step_reg + 5'd1;
                busy_next = ~word.last;
            end
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
                m_tvalid_next = 1'b0;
            if (s_tvalid)
            begin
                case (opcode)
                    chlcd_pkg::OP_INIT:
                    begin
                        busy_next = 1'b1;
                        step_next = chlcd_pkg::INIT_ENTRY;
                    end
                    chlcd_pkg::OP_COMMAND, chlcd_pkg::OP_DATA:
                    begin
                        busy_next = 1'b1;
                        step_next = chlcd_pkg::BYTE_ENTRY;
                        pending_byte_next = byte_value;
                        pending_select_next = (opcode == chlcd_pkg::OP_DATA);
                    end
                    chlcd_pkg::OP_MOVE:
                    begin
                        if (line[1] == 1'b0 && column[5:4] == 2'b00)
                        begin
                            busy_next = 1'b1;
                            step_next = chlcd_pkg::BYTE_ENTRY;
                            pending_byte_next = {1'b1, line[0], 2'b00, column[3:0]};
                            pending_select_next = 1'b0;
                        end
                    end
                    default: busy_next = busy_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            pending_byte_reg <= 8'd0;
            pending_select_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg <= 1'b0;
            strobe_wait_reg <= chlcd_pkg::STROBE_WAIT_RESET;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            pending_byte_reg <= pending_byte_next;
            pending_select_reg <= pending_select_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg <= m_tlast_next;
            if (psel && penable && pwrite && pready
                && paddr[2] == chlcd_pkg::ADDR_STROBE_WAIT && paddr[1:0] == 2'b00)
                strobe_wait_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= chlcd_pkg::LAST_ADDR)
        else $error("step counter outside program");

    a_init_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata[1:0] == chlcd_pkg::OP_INIT)
        |=> busy_reg && step_reg == chlcd_pkg::INIT_ENTRY)
        else $error("init request did not start init program");

    a_end_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> m_tvalid_reg && m_tlast_reg)
        else $error("program ended without a final transfer");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !load_ok) |=> $stable(step_reg))
        else $error("step advanced while output stalled");

endmodule
